FILE: hdl/imh_pkg.sv
// Package for the indexed min-heap: operation codes, status codes and widths.
// Used by every module of the block; depends on nothing.
package imh_pkg;
   localparam int LABEL_BITS = 10;
   localparam int LABEL_SPACE = 1024;
   localparam int REQ_BITS = 3;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_OUT_BITS = 11;

   localparam logic [REQ_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [REQ_BITS-1:0] OP_APPEND = 3'd1;
   localparam logic [REQ_BITS-1:0] OP_BUILD = 3'd2;
   localparam logic [REQ_BITS-1:0] OP_DELETE = 3'd3;
   localparam logic [REQ_BITS-1:0] OP_CHANGE = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd3;

   typedef logic [LABEL_BITS-1:0] label_type;
endpackage

FILE: hdl/imh_store.sv
// Heap slot memory holding label and key per slot, one port, registered read.
// Depends on imh_pkg.
module imh_store #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32,
   parameter int SLOT_BITS = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [SLOT_BITS-1:0]      addr,
   input  imh_pkg::label_type        wr_label,
   input  logic [KEY_BITS-1:0]       wr_key,
   output imh_pkg::label_type        rd_label,
   output logic [KEY_BITS-1:0]       rd_key
);
   import imh_pkg::*;
   logic [LABEL_BITS+KEY_BITS-1:0] mem [CAPACITY];
   logic [LABEL_BITS+KEY_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= {wr_label, wr_key};
      end
      rd_ff <= mem[addr];
   end

   assign rd_label = rd_ff[LABEL_BITS+KEY_BITS-1:KEY_BITS];
   assign rd_key = rd_ff[KEY_BITS-1:0];
endmodule

FILE: hdl/imh_pos.sv
// Position table from label to heap slot with a present bit per label, one registered read.
// After reset a clearing pass marks every label absent, one entry per cycle. Depends on imh_pkg.
module imh_pos #(
   parameter int SLOT_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  imh_pkg::label_type   wr_label,
   input  logic [SLOT_BITS-1:0] wr_slot,
   input  logic                 clr_en,
   input  imh_pkg::label_type   pres_label,
   input  imh_pkg::label_type   rd_label,
   output logic [SLOT_BITS-1:0] rd_slot,
   output logic                 rd_present,
   output logic                 clearing
);
   import imh_pkg::*;
   logic [SLOT_BITS:0] mem [LABEL_SPACE];
   logic [SLOT_BITS:0] rd_ff;
   logic clear_ff;
   label_type clr_idx_ff;

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_label] <= {1'b1, wr_slot};
      end else if (clr_en) begin
         mem[pres_label] <= '0;
      end
      rd_ff <= mem[rd_label];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clear_ff) begin
         clr_idx_ff <= clr_idx_ff + LABEL_BITS'(1);
         if (clr_idx_ff == LABEL_BITS'(LABEL_SPACE - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   assign rd_slot = rd_ff[SLOT_BITS-1:0];
   assign rd_present = rd_ff[SLOT_BITS];
   assign clearing = clear_ff;
endmodule

FILE: hdl/indexed_min_heap_top.sv
// Indexed binary min-heap with label position table and a sequencer that sifts.
// Insert and change key write the entry and sift it up or down; delete moves the last entry
// to the root and sifts it down; build heap sifts down each inner entry, last one first.
// One operation at a time: busy is high from start until the end of the rsp_strobe beat.
// Reset is synchronous: heap empty, then a clearing pass empties the label table with busy high.
// Depends on imh_pkg, imh_store and imh_pos; the receiver cannot stall.
module indexed_min_heap_top #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [imh_pkg::REQ_BITS-1:0]    req_type,
   input  logic [imh_pkg::LABEL_BITS-1:0]  req_label,
   input  logic [31:0]                     req_key,
   output logic                            rsp_strobe,
   output logic [imh_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [imh_pkg::LABEL_BITS-1:0]  rsp_out_label,
   output logic [31:0]                     rsp_out_key,
   output logic [10:0]                     rsp_count
);
   import imh_pkg::*;
   localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam logic [CNT_BITS-1:0] CAP_C = CNT_BITS'(CAPACITY);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_POSRD = 5'd1;
   localparam logic [4:0] S_DECIDE = 5'd2;
   localparam logic [4:0] S_CKRD = 5'd3;
   localparam logic [4:0] S_CKWAIT = 5'd4;
   localparam logic [4:0] S_CKWR = 5'd5;
   localparam logic [4:0] S_DLRD0 = 5'd6;
   localparam logic [4:0] S_DLRDL = 5'd7;
   localparam logic [4:0] S_DLWAIT = 5'd8;
   localparam logic [4:0] S_DLWR = 5'd9;
   localparam logic [4:0] S_UPRD = 5'd10;
   localparam logic [4:0] S_UPWAIT = 5'd11;
   localparam logic [4:0] S_UPCMP = 5'd12;
   localparam logic [4:0] S_UPWRC = 5'd13;
   localparam logic [4:0] S_DNRDL = 5'd14;
   localparam logic [4:0] S_DNRDR = 5'd15;
   localparam logic [4:0] S_DNWL = 5'd16;
   localparam logic [4:0] S_DNWR = 5'd17;
   localparam logic [4:0] S_DNCMP = 5'd18;
   localparam logic [4:0] S_DNWRC = 5'd19;
   localparam logic [4:0] S_BUILD = 5'd20;
   localparam logic [4:0] S_DONE = 5'd21;
   localparam logic [4:0] S_INSWR = 5'd22;
   localparam logic [4:0] S_DNRD = 5'd23;

   logic [4:0] state_ff, state_in;
   logic [REQ_BITS-1:0] op_ff, op_in;
   label_type lab_ff, lab_in;
   logic [KB-1:0] key_ff, key_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] cur_ff, cur_in;
   label_type cur_lab_ff, cur_lab_in;
   logic [KB-1:0] cur_key_ff, cur_key_in;
   logic [SLOT_BITS:0] oth_ff, oth_in;
   label_type oth_lab_ff, oth_lab_in;
   logic [KB-1:0] oth_key_ff, oth_key_in;
   logic have_ff, have_in;
   logic [CNT_BITS-1:0] bi_ff, bi_in;
   logic bmode_ff, bmode_in;
   logic [STATUS_BITS-1:0] st_ff, st_in;
   label_type olab_ff, olab_in;
   logic [KB-1:0] okey_ff, okey_in;
   logic strobe_ff, strobe_in;

   logic mem_we;
   logic [SLOT_BITS-1:0] mem_addr;
   label_type mem_wl, mem_rl;
   logic [KB-1:0] mem_wk, mem_rk;
   logic pos_we, pos_clr, pos_pres, pos_busy;
   label_type pos_wl, pos_pl;
   logic [SLOT_BITS-1:0] pos_ws, pos_rs;

   imh_store #(.CAPACITY(CAPACITY), .KEY_BITS(KB), .SLOT_BITS(SLOT_BITS)) u_store (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_label(mem_wl),
      .wr_key(mem_wk), .rd_label(mem_rl), .rd_key(mem_rk));

   imh_pos #(.SLOT_BITS(SLOT_BITS)) u_pos (
      .clock(clock), .reset(reset), .wr_en(pos_we), .wr_label(pos_wl), .wr_slot(pos_ws),
      .clr_en(pos_clr), .pres_label(pos_pl), .rd_label(lab_ff),
      .rd_slot(pos_rs), .rd_present(pos_pres), .clearing(pos_busy));

   logic [SLOT_BITS:0] lchild, rchild;
   logic [SLOT_BITS-1:0] parent;
   assign lchild = {cur_ff, 1'b1};
   assign rchild = {cur_ff, 1'b0} + (SLOT_BITS+1)'(2);
   assign parent = (cur_ff - SLOT_BITS'(1)) >> 1;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      lab_in = lab_ff;
      key_in = key_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      cur_lab_in = cur_lab_ff;
      cur_key_in = cur_key_ff;
      oth_in = oth_ff;
      oth_lab_in = oth_lab_ff;
      oth_key_in = oth_key_ff;
      have_in = have_ff;
      bi_in = bi_ff;
      bmode_in = bmode_ff;
      st_in = st_ff;
      olab_in = olab_ff;
      okey_in = okey_ff;
      strobe_in = 1'b0;
      mem_we = 1'b0;
      mem_addr = cur_ff;
      mem_wl = cur_lab_ff;
      mem_wk = cur_key_ff;
      pos_we = 1'b0;
      pos_wl = cur_lab_ff;
      pos_ws = cur_ff;
      pos_clr = 1'b0;
      pos_pl = lab_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               op_in = req_type;
               lab_in = req_label;
               key_in = req_key[KB-1:0];
               st_in = ST_OK;
               olab_in = '0;
               okey_in = '0;
               bmode_in = 1'b0;
               state_in = S_POSRD;
            end
         end
         S_POSRD: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (op_ff == OP_INSERT || op_ff == OP_APPEND) begin
               if (pos_pres) begin
                  cur_in = pos_rs;
                  state_in = S_CKRD;
               end else if (cnt_ff >= CAP_C) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  cur_in = cnt_ff[SLOT_BITS-1:0];
                  cur_lab_in = lab_ff;
                  cur_key_in = key_ff;
                  state_in = S_INSWR;
               end
            end else if (op_ff == OP_CHANGE) begin
               if (pos_pres) begin
                  cur_in = pos_rs;
                  state_in = S_CKRD;
               end else begin
                  st_in = ST_ABSENT;
                  state_in = S_DONE;
               end
            end else if (op_ff == OP_DELETE) begin
               if (cnt_ff == '0) begin
                  st_in = ST_EMPTY;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DLRD0;
               end
            end else if (op_ff == OP_BUILD) begin
               bi_in = cnt_ff >> 1;
               bmode_in = 1'b1;
               state_in = S_BUILD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INSWR: begin
            mem_we = 1'b1;
            pos_we = 1'b1;
            cnt_in = cnt_ff + CNT_BITS'(1);
            state_in = (op_ff == OP_INSERT) ? S_UPRD : S_DONE;
         end
         S_CKRD: begin
            state_in = S_CKWAIT;
         end
         S_CKWAIT: begin
            cur_lab_in = mem_rl;
            cur_key_in = key_ff;
            oth_key_in = mem_rk;
            state_in = S_CKWR;
         end
         S_CKWR: begin
            mem_we = 1'b1;
            priority if (key_ff < oth_key_ff) begin
               state_in = S_UPRD;
            end else if (key_ff > oth_key_ff) begin
               state_in = S_DNRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DLRD0: begin
            mem_addr = '0;
            state_in = S_DLRDL;
         end
         S_DLRDL: begin
            olab_in = mem_rl;
            okey_in = mem_rk;
            mem_addr = SLOT_BITS'(cnt_ff - CNT_BITS'(1));
            cnt_in = cnt_ff - CNT_BITS'(1);
            state_in = S_DLWAIT;
         end
         S_DLWAIT: begin
            cur_in = '0;
            cur_lab_in = mem_rl;
            cur_key_in = mem_rk;
            pos_pl = olab_ff;
            pos_clr = 1'b1;
            state_in = (cnt_ff == '0) ? S_DONE : S_DLWR;
         end
         S_DLWR: begin
            mem_we = 1'b1;
            pos_we = 1'b1;
            state_in = S_DNRD;
         end
         S_UPRD: begin
            if (cur_ff == '0) begin
               state_in = bmode_ff ? S_BUILD : S_DONE;
            end else begin
               mem_addr = parent;
               state_in = S_UPWAIT;
            end
         end
         S_UPWAIT: begin
            mem_addr = parent;
            state_in = S_UPCMP;
         end
         S_UPCMP: begin
            if (cur_key_ff < mem_rk) begin
               mem_we = 1'b1;
               mem_wl = mem_rl;
               mem_wk = mem_rk;
               pos_we = 1'b1;
               pos_wl = mem_rl;
               cur_in = parent;
               state_in = S_UPWRC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_UPWRC: begin
            mem_we = 1'b1;
            pos_we = 1'b1;
            state_in = S_UPRD;
         end
         S_DNRD: begin
            have_in = 1'b0;
            oth_key_in = cur_key_ff;
            if ({1'b0, lchild} < (SLOT_BITS+2)'(cnt_ff)) begin
               mem_addr = lchild[SLOT_BITS-1:0];
               state_in = S_DNRDL;
            end else begin
               state_in = S_DNCMP;
            end
         end
         S_DNRDL: begin
            mem_addr = lchild[SLOT_BITS-1:0];
            state_in = S_DNWL;
         end
         S_DNWL: begin
            mem_addr = rchild[SLOT_BITS-1:0];
            if (mem_rk < oth_key_ff) begin
               have_in = 1'b1;
               oth_in = lchild;
               oth_lab_in = mem_rl;
               oth_key_in = mem_rk;
            end
            state_in = ({1'b0, rchild} < (SLOT_BITS+2)'(cnt_ff)) ? S_DNWR : S_DNCMP;
         end
         S_DNWR: begin
            if (mem_rk < oth_key_ff) begin
               have_in = 1'b1;
               oth_in = rchild;
               oth_lab_in = mem_rl;
               oth_key_in = mem_rk;
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (have_ff) begin
               mem_we = 1'b1;
               mem_wl = oth_lab_ff;
               mem_wk = oth_key_ff;
               pos_we = 1'b1;
               pos_wl = oth_lab_ff;
               cur_in = oth_ff[SLOT_BITS-1:0];
               state_in = S_DNWRC;
            end else begin
               state_in = bmode_ff ? S_BUILD : S_DONE;
            end
         end
         S_DNWRC: begin
            mem_we = 1'b1;
            pos_we = 1'b1;
            state_in = S_DNRD;
         end
         S_BUILD: begin
            if (bi_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bi_in = bi_ff - CNT_BITS'(1);
               cur_in = SLOT_BITS'(bi_ff - CNT_BITS'(1));
               mem_addr = SLOT_BITS'(bi_ff - CNT_BITS'(1));
               state_in = S_CKWAIT;
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (state_ff == S_CKWAIT && bmode_ff) begin
         cur_key_in = mem_rk;
         state_in = S_DNRD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         strobe_ff <= 1'b0;
         bmode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         strobe_ff <= strobe_in;
         bmode_ff <= bmode_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      lab_ff <= lab_in;
      key_ff <= key_in;
      cur_ff <= cur_in;
      cur_lab_ff <= cur_lab_in;
      cur_key_ff <= cur_key_in;
      oth_ff <= oth_in;
      oth_lab_ff <= oth_lab_in;
      oth_key_ff <= oth_key_in;
      have_ff <= have_in;
      bi_ff <= bi_in;
      st_ff <= st_in;
      olab_ff <= olab_in;
      okey_ff <= okey_in;
   end

   assign busy = (state_ff != S_IDLE) || strobe_ff || pos_busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = st_ff;
   assign rsp_out_label = olab_ff;
   assign rsp_out_key = 32'(okey_ff);
   assign rsp_count = 11'(cnt_ff);
endmodule

FILE: dv/tb.sv
// Self-checking testbench for indexed_min_heap_top: directed and random heap operations.
// A behavioral heap with a label position table predicts every response beat.
// Depends on imh_pkg and the indexed_min_heap_top RTL.
`timescale 1ns / 1ps

module tb;
   import imh_pkg::*;

   localparam logic [REQ_BITS-1:0] OP_SPARE5 = 3'd5;
   localparam logic [REQ_BITS-1:0] OP_SPARE6 = 3'd6;
   localparam logic [REQ_BITS-1:0] OP_SPARE7 = 3'd7;
   localparam int HEAP_SLOTS = 1024;

   typedef struct {
      logic                  hold;
      logic [REQ_BITS-1:0]   op;
      label_type             lab;
      logic [31:0]           key;
   } op_beat_type;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      label_type              lab;
      logic [31:0]            key;
      logic [10:0]            count;
   } rsp_beat_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [REQ_BITS-1:0] req_type = '0;
   label_type req_label = '0;
   logic [31:0] req_key = '0;
   logic rsp_strobe;
   logic [STATUS_BITS-1:0] rsp_status;
   label_type rsp_out_label;
   logic [31:0] rsp_out_key;
   logic [10:0] rsp_count;

   op_beat_type pending_ops[$];
   rsp_beat_type expected_rsp[$];
   logic took = 0;
   int sent = 0;
   int mismatches = 0;

   label_type   heap_lab[HEAP_SLOTS];
   logic [31:0] heap_key[HEAP_SLOTS];
   int          slot_of[LABEL_SPACE];
   bit          present[LABEL_SPACE];
   int          heap_count = 0;

   always #2 clock = ~clock;

   indexed_min_heap_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_label(req_label), .req_key(req_key),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_label(rsp_out_label),
      .rsp_out_key(rsp_out_key), .rsp_count(rsp_count)
   );

   function automatic void place(int s, label_type l, logic [31:0] k);
      heap_lab[s] = l;
      heap_key[s] = k;
      slot_of[l] = s;
   endfunction

   function automatic void swap_slots(int a, int b);
      label_type l;
      logic [31:0] k;
      l = heap_lab[a];
      k = heap_key[a];
      place(a, heap_lab[b], heap_key[b]);
      place(b, l, k);
   endfunction

   function automatic void heap_rise(int s);
      int p;
      while (s > 0) begin
         p = (s - 1) / 2;
         if (heap_key[s] < heap_key[p]) begin
            swap_slots(p, s);
            s = p;
         end else break;
      end
   endfunction

   function automatic void heap_sink(int s);
      int l, r, m;
      forever begin
         l = 2 * s + 1;
         r = 2 * s + 2;
         m = s;
         if (l < heap_count && heap_key[l] < heap_key[m]) m = l;
         if (r < heap_count && heap_key[r] < heap_key[m]) m = r;
         if (m == s) break;
         swap_slots(s, m);
         s = m;
      end
   endfunction

   function automatic void rekey(label_type l, logic [31:0] k);
      int s;
      logic [31:0] old;
      s = slot_of[l];
      old = heap_key[s];
      heap_key[s] = k;
      if (k < old) heap_rise(s);
      else if (k > old) heap_sink(s);
   endfunction

   function automatic rsp_beat_type heap_apply(logic [REQ_BITS-1:0] op, label_type l,
                                               logic [31:0] k);
      rsp_beat_type r;
      int i;
      label_type ml;
      r = '{ST_OK, '0, '0, '0};
      case (op)
         OP_INSERT, OP_APPEND: begin
            if (present[l]) rekey(l, k);
            else if (heap_count >= HEAP_SLOTS) r.status = ST_FULL;
            else begin
               present[l] = 1;
               place(heap_count, l, k);
               heap_count++;
               if (op == OP_INSERT) heap_rise(heap_count - 1);
            end
         end
         OP_BUILD: begin
            for (i = heap_count / 2 - 1; i >= 0; i--) heap_sink(i);
         end
         OP_DELETE: begin
            if (heap_count == 0) r.status = ST_EMPTY;
            else begin
               ml = heap_lab[0];
               r.lab = ml;
               r.key = heap_key[0];
               heap_count--;
               if (heap_count > 0) begin
                  place(0, heap_lab[heap_count], heap_key[heap_count]);
                  heap_sink(0);
               end
               present[ml] = 0;
            end
         end
         OP_CHANGE: begin
            if (!present[l]) r.status = ST_ABSENT;
            else rekey(l, k);
         end
         default: ;
      endcase
      r.count = heap_count[10:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_beat_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response beat: status %0d label %0d key %h count %0d",
                           rsp_status, rsp_out_label, rsp_out_key, rsp_count);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status || rsp_out_label !== want.lab ||
                   rsp_out_key !== want.key || rsp_count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                              want.status, want.lab, want.key, want.count, rsp_status,
                              rsp_out_label, rsp_out_key, rsp_count);
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(heap_apply(req_type, req_label, req_key));
         took <= start && !busy;
      end
   end

   always @(negedge clock) begin : driver
      op_beat_type it;
      if (reset) start <= 0;
      else if (!start || took) begin
         if (pending_ops.size() == 0) start <= 0;
         else if (pending_ops[0].hold) begin
            if (expected_rsp.size() == 0) it = pending_ops.pop_front();
            start <= 0;
         end else if ((sent < 200 || sent >= 400) && $urandom_range(99) < 18) start <= 0;
         else begin
            it = pending_ops.pop_front();
            start <= 1;
            req_type <= it.op;
            req_label <= it.lab;
            req_key <= it.key;
            sent++;
         end
      end
   end

   task automatic add_op(logic [REQ_BITS-1:0] op, label_type l, logic [31:0] k);
      pending_ops.push_back('{1'b0, op, l, k});
   endtask

   initial begin : stimulus
      int n, w;
      label_type l;
      logic [31:0] k;
      logic [REQ_BITS-1:0] op;
      for (n = 0; n < LABEL_SPACE; n++) present[n] = 0;
      add_op(OP_DELETE, 10'd0, 32'd0);
      add_op(OP_BUILD, 10'd0, 32'd0);
      add_op(OP_CHANGE, 10'd5, 32'd9);
      add_op(OP_INSERT, 10'd0, 32'hFFFF_FFFF);
      add_op(OP_INSERT, 10'd1023, 32'd0);
      add_op(OP_APPEND, 10'd512, 32'd7);
      add_op(OP_APPEND, 10'd3, 32'd7);
      add_op(OP_APPEND, 10'd7, 32'd7);
      add_op(OP_APPEND, 10'd341, 32'hAAAA_5555);
      add_op(OP_BUILD, 10'd0, 32'd0);
      add_op(OP_INSERT, 10'd0, 32'd1);
      add_op(OP_APPEND, 10'd1023, 32'hFFFF_FFFF);
      add_op(OP_CHANGE, 10'd512, 32'd0);
      add_op(OP_CHANGE, 10'd512, 32'd0);
      add_op(OP_CHANGE, 10'd3, 32'h5555_AAAA);
      add_op(OP_SPARE5, 10'd682, 32'd1);
      add_op(OP_SPARE6, 10'd1, 32'd2);
      add_op(OP_SPARE7, 10'd2, 32'd3);
      repeat (4) add_op(OP_DELETE, 10'd0, 32'd0);
      pending_ops.push_back('{1'b1, OP_BUILD, 10'd0, 32'd0});
      for (n = 0; n < 580; n++) begin
         if (n == 500) pending_ops.push_back('{1'b1, OP_BUILD, 10'd0, 32'd0});
         w = $urandom_range(99);
         if (w < 30) op = OP_INSERT;
         else if (w < 45) op = OP_APPEND;
         else if (w < 52) op = OP_BUILD;
         else if (w < 77) op = OP_DELETE;
         else if (w < 95) op = OP_CHANGE;
         else op = OP_SPARE5 + REQ_BITS'($urandom_range(2));
         l = ($urandom_range(9) < 7) ? label_type'($urandom_range(63)) : label_type'($urandom);
         k = ($urandom_range(1) == 1) ? $urandom : $urandom_range(15);
         add_op(op, l, k);
      end
      repeat (250) add_op(OP_DELETE, 10'd0, 32'd0);
      repeat (2) @(posedge clock);
      reset <= 0;
      while (pending_ops.size() != 0 || start || expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/imh_pkg.sv
hdl/imh_store.sv
hdl/imh_pos.sv
hdl/indexed_min_heap_top.sv
dv/tb.sv
